FILE: sv/dda_pkg.sv
// Shared widths, codes and bundle types of the line rasterizer.
package dda_pkg;

   // Fixed field widths
   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int POS_BITS   = COORD_BITS + FRAC_BITS;
   localparam int DIM_W      = 14;
   localparam int COLOR_W    = 32;
   localparam int ADDR_W     = 26;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Divider widths: magnitudes of a delta, and a quotient of at most one whole
   localparam int DIV_W  = COORD_BITS + 1;
   localparam int QUOT_W = FRAC_BITS + 1;

   // Request actions
   localparam logic ACTION_START = 1'b0;
   localparam logic ACTION_STEP  = 1'b1;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IMAGE_WIDTH  = 3'd0,
      REG_IMAGE_HEIGHT = 3'd1,
      REG_ROW_STRIDE   = 3'd2,
      REG_COLOR_RAISED = 3'd3,
      REG_COLOR_FLAT   = 3'd4
   } csr_index_type;

   // Reset values of the registers
   localparam logic [DIM_W-1:0]   IMAGE_WIDTH_RST  = DIM_W'(1024);
   localparam logic [DIM_W-1:0]   IMAGE_HEIGHT_RST = DIM_W'(768);
   localparam logic [DIM_W-1:0]   ROW_STRIDE_RST   = DIM_W'(1024);
   localparam logic [COLOR_W-1:0] COLOR_RAISED_RST = COLOR_W'(24'hFF_FFFF);
   localparam logic [COLOR_W-1:0] COLOR_FLAT_RST   = '0;

   typedef struct packed {
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
      logic [DIM_W-1:0]   stride;
      logic [COLOR_W-1:0] color_raised;
      logic [COLOR_W-1:0] color_flat;
   } cfg_type;

   typedef struct packed {
      logic                         active;
      logic                         raised;
      logic signed [POS_BITS-1:0]   pos_x;
      logic signed [POS_BITS-1:0]   pos_y;
      logic signed [COORD_BITS-1:0] target_x;
      logic signed [COORD_BITS-1:0] target_y;
   } line_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic [ADDR_W-1:0]            addr;
      logic [COLOR_W-1:0]           color;
      logic                         visible;
      logic                         last;
   } pixel_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: sv/dda_if.sv
// Channel interfaces of the line rasterizer: request, pixel response, register write.
interface dda_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  action;
   logic signed [dda_pkg::COORD_BITS-1:0] x_start;
   logic signed [dda_pkg::COORD_BITS-1:0] y_start;
   logic signed [dda_pkg::COORD_BITS-1:0] x_end;
   logic signed [dda_pkg::COORD_BITS-1:0] y_end;
   logic                                  raised;

   modport source (output valid, action, x_start, y_start, x_end, y_end, raised,
                   input ready);
   modport sink   (input valid, action, x_start, y_start, x_end, y_end, raised,
                   output ready);
endinterface

interface dda_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [dda_pkg::COORD_BITS-1:0] pixel_x;
   logic signed [dda_pkg::COORD_BITS-1:0] pixel_y;
   logic [dda_pkg::ADDR_W-1:0]            pixel_addr;
   logic [dda_pkg::COLOR_W-1:0]           pixel_color;
   logic                                  visible;
   logic                                  last;

   modport source (output valid, pixel_x, pixel_y, pixel_addr, pixel_color, visible, last,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_addr, pixel_color, visible, last,
                   output ready);
endinterface

interface dda_csr_if;
   logic                            valid;
   logic                            ready;
   logic [dda_pkg::CSR_IDX_W-1:0]   index;
   logic [dda_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/dda_line_rasterizer.sv
// Top level of the DDA line rasterizer: sequencer, line state, registers, output stage.
//
//  channel | dir | handshake   | beat contents
//  --------+-----+-------------+---------------------------------------------------
//  req_ch  | in  | valid/ready | action, x_start, y_start, x_end, y_end, raised
//  rsp_ch  | out | valid/ready | pixel_x, pixel_y, pixel_addr, pixel_color, visible, last
//  csr_ch  | in  | valid/ready | index, data (always ready)
//
// A step beat loads the output register; the next beat is taken
// while that pixel waits, as long as rsp_ch drains it in the same cycle.
// A start beat keeps req_ch.ready low while the single restoring divider runs once
// for the x increment, then for y.
// Reset is synchronous, active high; it returns the line to idle and the registers
// to their defaults. A stalled rsp_ch holds its beat and blocks req_ch.
module dda_line_rasterizer (
   input  logic             clock,
   input  logic             reset,
   dda_req_if.sink          req_ch,
   dda_rsp_if.source        rsp_ch,
   dda_csr_if.sink          csr_ch
);

   localparam int PB = dda_pkg::POS_BITS;
   localparam int CB = dda_pkg::COORD_BITS;
   localparam int DW = dda_pkg::DIV_W;
   localparam int QW = dda_pkg::QUOT_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_X,
      ST_DIV_Y
   } state_type;

   // Signed increment from quotient; a zero-length line steps by nothing
   function automatic logic [PB-1:0] signed_step(input logic neg, input logic zero,
                                                 input logic [QW-1:0] q);
      logic [PB-1:0] mag;
      mag = PB'(q);
      if (zero) return '0;
      return neg ? -mag : mag;
   endfunction

   state_type            state_ff, state_in;
   logic                 active_ff, active_in;
   logic                 raised_ff, raised_in;
   logic [PB-1:0]        pos_x_ff, pos_x_in;
   logic [PB-1:0]        pos_y_ff, pos_y_in;
   logic [PB-1:0]        step_x_ff, step_x_in;
   logic [PB-1:0]        step_y_ff, step_y_in;
   logic [CB-1:0]        target_x_ff, target_x_in;
   logic [CB-1:0]        target_y_ff, target_y_in;
   logic [DW-1:0]        mag_x_ff, mag_x_in;
   logic [DW-1:0]        mag_y_ff, mag_y_in;
   logic [DW-1:0]        span_ff, span_in;
   logic                 neg_x_ff, neg_x_in;
   logic                 neg_y_ff, neg_y_in;
   logic                 div_start_ff, div_start_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   dda_pkg::pixel_type   rsp_pix_ff, rsp_pix_in;

   dda_pkg::cfg_type     cfg_ff;
   dda_pkg::line_type    ln_view;
   dda_pkg::pixel_type   pix;
   dda_pkg::div_req_type div_req;
   dda_pkg::div_rsp_type div_rsp;

   logic                 req_accept;
   logic signed [DW-1:0] dx;
   logic signed [DW-1:0] dy;
   logic [DW-1:0]        abs_dx;
   logic [DW-1:0]        abs_dy;

   // Register writes
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width        <= dda_pkg::IMAGE_WIDTH_RST;
         cfg_ff.height       <= dda_pkg::IMAGE_HEIGHT_RST;
         cfg_ff.stride       <= dda_pkg::ROW_STRIDE_RST;
         cfg_ff.color_raised <= dda_pkg::COLOR_RAISED_RST;
         cfg_ff.color_flat   <= dda_pkg::COLOR_FLAT_RST;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            dda_pkg::REG_IMAGE_WIDTH:  cfg_ff.width        <= csr_ch.data[dda_pkg::DIM_W-1:0];
            dda_pkg::REG_IMAGE_HEIGHT: cfg_ff.height       <= csr_ch.data[dda_pkg::DIM_W-1:0];
            dda_pkg::REG_ROW_STRIDE:   cfg_ff.stride       <= csr_ch.data[dda_pkg::DIM_W-1:0];
            dda_pkg::REG_COLOR_RAISED: cfg_ff.color_raised <= csr_ch.data;
            dda_pkg::REG_COLOR_FLAT:   cfg_ff.color_flat   <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // Pixel evaluation of the current position
   assign ln_view.active   = active_ff;
   assign ln_view.raised   = raised_ff;
   assign ln_view.pos_x    = pos_x_ff;
   assign ln_view.pos_y    = pos_y_ff;
   assign ln_view.target_x = target_x_ff;
   assign ln_view.target_y = target_y_ff;

   dda_pix u_pix (
      .ln_state (ln_view),
      .cfg      (cfg_ff),
      .pixel    (pix)
   );

   // Shared divider, fed x then y
   assign div_req.start    = div_start_ff;
   assign div_req.dividend = (state_ff == ST_DIV_Y) ? mag_y_ff : mag_x_ff;
   assign div_req.divisor  = span_ff;

   dda_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Handshake
   assign req_ch.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_accept   = req_ch.valid && req_ch.ready;

   // Deltas of a start beat
   always_comb begin
      dx     = DW'(req_ch.x_end) - DW'(req_ch.x_start);
      dy     = DW'(req_ch.y_end) - DW'(req_ch.y_start);
      abs_dx = dx[DW-1] ? -dx : dx;
      abs_dy = dy[DW-1] ? -dy : dy;
   end

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      raised_in    = raised_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      step_x_in    = step_x_ff;
      step_y_in    = step_y_ff;
      target_x_in  = target_x_ff;
      target_y_in  = target_y_ff;
      mag_x_in     = mag_x_ff;
      mag_y_in     = mag_y_ff;
      span_in      = span_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      div_start_in = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_pix_in   = rsp_pix_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_ch.action == dda_pkg::ACTION_START) begin
                  // load a new line, dropping any old one
                  pos_x_in     = {req_ch.x_start, {dda_pkg::FRAC_BITS{1'b0}}};
                  pos_y_in     = {req_ch.y_start, {dda_pkg::FRAC_BITS{1'b0}}};
                  target_x_in  = req_ch.x_end;
                  target_y_in  = req_ch.y_end;
                  raised_in    = req_ch.raised;
                  active_in    = 1'b1;
                  mag_x_in     = abs_dx;
                  mag_y_in     = abs_dy;
                  span_in      = (abs_dx > abs_dy) ? abs_dx : abs_dy;
                  neg_x_in     = dx[DW-1];
                  neg_y_in     = dy[DW-1];
                  div_start_in = 1'b1;
                  state_in     = ST_DIV_X;
               end else begin
                  // emit the pixel, then advance or close the line
                  rsp_valid_in = 1'b1;
                  rsp_pix_in   = pix;
                  if (active_ff) begin
                     if (pix.last) begin
                        active_in = 1'b0;
                     end else begin
                        pos_x_in = pos_x_ff + step_x_ff;
                        pos_y_in = pos_y_ff + step_y_ff;
                     end
                  end
               end
            end
         end
         ST_DIV_X: begin
            if (div_rsp.done) begin
               step_x_in    = signed_step(neg_x_ff, span_ff == '0, div_rsp.quotient);
               div_start_in = 1'b1;
               state_in     = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (div_rsp.done) begin
               step_y_in = signed_step(neg_y_ff, span_ff == '0, div_rsp.quotient);
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         raised_ff    <= 1'b0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         step_x_ff    <= '0;
         step_y_ff    <= '0;
         target_x_ff  <= '0;
         target_y_ff  <= '0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         raised_ff    <= raised_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         step_x_ff    <= step_x_in;
         step_y_ff    <= step_y_in;
         target_x_ff  <= target_x_in;
         target_y_ff  <= target_y_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_x_ff   <= mag_x_in;
      mag_y_ff   <= mag_y_in;
      span_ff    <= span_in;
      neg_x_ff   <= neg_x_in;
      neg_y_ff   <= neg_y_in;
      rsp_pix_ff <= rsp_pix_in;
   end

   // Response channel
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.pixel_x     = rsp_pix_ff.x;
   assign rsp_ch.pixel_y     = rsp_pix_ff.y;
   assign rsp_ch.pixel_addr  = rsp_pix_ff.addr;
   assign rsp_ch.pixel_color = rsp_pix_ff.color;
   assign rsp_ch.visible     = rsp_pix_ff.visible;
   assign rsp_ch.last        = rsp_pix_ff.last;

endmodule

FILE: sv/dda_div.sv
// Restoring divider, one quotient bit per cycle: dividend * 2^FRAC_BITS / divisor.
module dda_div (
   input  logic                 clock,
   input  logic                 reset,
   input  dda_pkg::div_req_type req,
   output dda_pkg::div_rsp_type rsp
);

   localparam int CNT_W = $clog2(dda_pkg::QUOT_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(dda_pkg::QUOT_W - 1);

   logic                         busy_ff;
   logic                         done_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic [dda_pkg::DIV_W:0]      rem_ff;
   logic [dda_pkg::DIV_W-1:0]    den_ff;
   logic [dda_pkg::QUOT_W-1:0]   quot_ff;

   logic [dda_pkg::DIV_W:0]      cand;
   logic                         fits;
   logic [dda_pkg::DIV_W:0]      rem_next;

   // First pass takes the whole part (dividend never exceeds divisor), later passes shift
   always_comb begin
      cand     = (cnt_ff == '0) ? rem_ff : {rem_ff[dda_pkg::DIV_W-1:0], 1'b0};
      fits     = cand >= {1'b0, den_ff};
      rem_next = fits ? cand - {1'b0, den_ff} : cand;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (busy_ff) begin
            rem_ff  <= rem_next;
            quot_ff <= {quot_ff[dda_pkg::QUOT_W-2:0], fits};
            cnt_ff  <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end else if (req.start) begin
            // load operands
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= {1'b0, req.dividend};
            den_ff  <= req.divisor;
            quot_ff <= '0;
         end
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quot_ff;

endmodule

FILE: sv/dda_pix.sv
// Pixel evaluation for one step: truncated position, end test, clipping and address.
module dda_pix (
   input  dda_pkg::line_type  ln_state,
   input  dda_pkg::cfg_type   cfg,
   output dda_pkg::pixel_type pixel
);

   localparam int PB = dda_pkg::POS_BITS;
   localparam int CB = dda_pkg::COORD_BITS;
   localparam int FB = dda_pkg::FRAC_BITS;
   localparam logic signed [PB:0] ONE_FIX     = (PB+1)'(1) <<< FB;
   localparam logic signed [PB:0] NEG_ONE_FIX = -ONE_FIX;

   // Truncate a fixed-point value toward zero
   function automatic logic [CB-1:0] trunc_fix(input logic [PB-1:0] v);
      logic [PB:0] ext;
      logic [PB:0] mag;
      logic [CB:0] q;
      ext = {v[PB-1], v};
      mag = v[PB-1] ? -ext : ext;
      q   = mag[PB:FB];
      return v[PB-1] ? CB'(-q) : CB'(q);
   endfunction

   logic [CB-1:0]       px;
   logic [CB-1:0]       py;
   logic signed [PB:0]  diff_x;
   logic signed [PB:0]  diff_y;
   logic                at_end;
   logic                vis;
   logic [CB+dda_pkg::DIM_W-1:0] prod;

   always_comb begin
      px = trunc_fix(ln_state.pos_x);
      py = trunc_fix(ln_state.pos_y);

      // end reached once both distances truncate to zero
      diff_x = {ln_state.target_x[CB-1], ln_state.target_x, {FB{1'b0}}}
               - {ln_state.pos_x[PB-1], ln_state.pos_x};
      diff_y = {ln_state.target_y[CB-1], ln_state.target_y, {FB{1'b0}}}
               - {ln_state.pos_y[PB-1], ln_state.pos_y};
      at_end = (diff_x < ONE_FIX) && (diff_x > NEG_ONE_FIX) &&
               (diff_y < ONE_FIX) && (diff_y > NEG_ONE_FIX);

      // clip against the frame, exclusive bounds
      vis = !ln_state.pos_x[PB-1] && !ln_state.pos_y[PB-1] &&
            (px < CB'(cfg.width)) && (py < CB'(cfg.height));

      prod = {{dda_pkg::DIM_W{1'b0}}, py} * {{CB{1'b0}}, cfg.stride};

      if (ln_state.active) begin
         pixel.x       = px;
         pixel.y       = py;
         pixel.addr    = vis ? dda_pkg::ADDR_W'(prod) + dda_pkg::ADDR_W'(px) : '0;
         pixel.color   = ln_state.raised ? cfg.color_raised : cfg.color_flat;
         pixel.visible = vis;
         pixel.last    = at_end;
      end else begin
         // idle step: blank terminal pixel
         pixel.x       = '0;
         pixel.y       = '0;
         pixel.addr    = '0;
         pixel.color   = '0;
         pixel.visible = 1'b0;
         pixel.last    = 1'b1;
      end
   end

endmodule

FILE: tb/tb_top.sv
// Self-checking bench for the DDA line rasterizer: line walks, register phases, flow stalls.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dda_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int SETTLE       = 60;    // covers the two divider passes of a start beat
   localparam int PHASES       = 8;
   localparam int PHASE_BEATS  = 210;
   localparam int LONG_HOLD    = 400;
   localparam int GAP_MAX      = 17;
   localparam logic [CSR_IDX_W-1:0] FIRST_SPARE_REG = CSR_IDX_W'(REG_COLOR_FLAT) + 1'b1;

   typedef struct packed {
      logic                         action;
      logic signed [COORD_BITS-1:0] x_start;
      logic signed [COORD_BITS-1:0] y_start;
      logic signed [COORD_BITS-1:0] x_end;
      logic signed [COORD_BITS-1:0] y_end;
      logic                         raised;
   } line_cmd_type;

   // Tracks the line being walked and the frame registers; predicts and checks pixels
   class line_scoreboard;
      localparam int PRINT_CAP = 40;

      logic [DIM_W-1:0]             width, height, stride;
      logic [COLOR_W-1:0]           color_raised, color_flat;
      logic                         active, raised;
      logic signed [POS_BITS-1:0]   pos_x, pos_y, inc_x, inc_y;
      logic signed [COORD_BITS-1:0] target_x, target_y;
      pixel_type                    pixels_due[$];
      int                           errors;
      int                           printed;

      function new();
         width        = IMAGE_WIDTH_RST;
         height       = IMAGE_HEIGHT_RST;
         stride       = ROW_STRIDE_RST;
         color_raised = COLOR_RAISED_RST;
         color_flat   = COLOR_FLAT_RST;
         active       = 1'b0;
         raised       = 1'b0;
         pos_x        = '0;
         pos_y        = '0;
         inc_x        = '0;
         inc_y        = '0;
         target_x     = '0;
         target_y     = '0;
         errors       = 0;
         printed      = 0;
      endfunction

      task report(string what);
         errors++;
         if (printed < PRINT_CAP) begin
            printed++;
            $display("MISMATCH @%0t: %s", $time, what);
         end
      endtask

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            REG_IMAGE_WIDTH:  width        = data[DIM_W-1:0];
            REG_IMAGE_HEIGHT: height       = data[DIM_W-1:0];
            REG_ROW_STRIDE:   stride       = data[DIM_W-1:0];
            REG_COLOR_RAISED: color_raised = data;
            REG_COLOR_FLAT:   color_flat   = data;
            default: ;
         endcase
      endfunction

      // Truncate a fixed-point value toward zero
      static function longint toward_zero(longint v);
         longint mag;
         mag = (v < 0) ? -v : v;
         mag = mag >>> FRAC_BITS;
         return (v < 0) ? -mag : mag;
      endfunction

      // delta / span in fixed point, truncated toward zero
      static function logic [POS_BITS-1:0] increment(int delta, int span);
         longint q;
         if (span == 0)
            return '0;
         q = (longint'(delta < 0 ? -delta : delta) <<< FRAC_BITS) / span;
         if (delta < 0)
            q = -q;
         return q[POS_BITS-1:0];
      endfunction

      // Emit the pixel at the current position, then advance or close the line
      function pixel_type walk_pixel();
         pixel_type pix;
         longint    fx, fy, px, py, left_x, left_y;
         pix = '0;
         if (!active) begin
            pix.last = 1'b1;
            return pix;
         end
         fx     = pos_x;
         fy     = pos_y;
         px     = toward_zero(fx);
         py     = toward_zero(fy);
         left_x = toward_zero((longint'(target_x) <<< FRAC_BITS) - fx);
         left_y = toward_zero((longint'(target_y) <<< FRAC_BITS) - fy);
         pix.x       = px[COORD_BITS-1:0];
         pix.y       = py[COORD_BITS-1:0];
         pix.color   = raised ? color_raised : color_flat;
         pix.visible = fx >= 0 && fy >= 0 && px < longint'(width) && py < longint'(height);
         if (pix.visible)
            pix.addr = ADDR_W'(px + py * longint'(stride));
         pix.last = (left_x == 0) && (left_y == 0);
         if (pix.last) begin
            active = 1'b0;
         end else begin
            pos_x = pos_x + inc_x;
            pos_y = pos_y + inc_y;
         end
         return pix;
      endfunction

      function void note_request(line_cmd_type cmd);
         int dx, dy, mag_x, mag_y;
         if (cmd.action == ACTION_START) begin
            dx       = int'(cmd.x_end) - int'(cmd.x_start);
            dy       = int'(cmd.y_end) - int'(cmd.y_start);
            mag_x    = dx < 0 ? -dx : dx;
            mag_y    = dy < 0 ? -dy : dy;
            pos_x    = {cmd.x_start, {FRAC_BITS{1'b0}}};
            pos_y    = {cmd.y_start, {FRAC_BITS{1'b0}}};
            inc_x    = increment(dx, mag_x > mag_y ? mag_x : mag_y);
            inc_y    = increment(dy, mag_x > mag_y ? mag_x : mag_y);
            target_x = cmd.x_end;
            target_y = cmd.y_end;
            raised   = cmd.raised;
            active   = 1'b1;
         end else begin
            pixels_due.push_back(walk_pixel());
         end
      endfunction

      task check_pixel(pixel_type got);
         pixel_type want;
         if (pixels_due.size() == 0) begin
            report($sformatf("pixel (%0d,%0d) arrived with none due", got.x, got.y));
            return;
         end
         want = pixels_due.pop_front();
         if (got.x !== want.x)
            report($sformatf("pixel_x got %0d want %0d", got.x, want.x));
         if (got.y !== want.y)
            report($sformatf("pixel_y got %0d want %0d", got.y, want.y));
         if (got.addr !== want.addr)
            report($sformatf("pixel_addr got %0h want %0h", got.addr, want.addr));
         if (got.color !== want.color)
            report($sformatf("pixel_color got %0h want %0h", got.color, want.color));
         if (got.visible !== want.visible)
            report($sformatf("visible got %0b want %0b", got.visible, want.visible));
         if (got.last !== want.last)
            report($sformatf("last got %0b want %0b", got.last, want.last));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic rsp_hold;
   int   cycle_count = 0;
   int   req_gap_max = GAP_MAX;
   int   rsp_gap_max = GAP_MAX;

   line_scoreboard board = new();

   dda_req_if req_ch ();
   dda_rsp_if rsp_ch ();
   dda_csr_if csr_ch ();

   dda_line_rasterizer DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Guard against a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // Pixel sink: random stalls, plus the long hold-off when asked
   initial begin : pixel_sink
      int        stall;
      pixel_type got;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = rsp_gap_max > 0 ? $urandom_range(0, rsp_gap_max) : 0;
         if (stall > 0 || rsp_hold) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
            while (rsp_hold) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         got.x       = rsp_ch.pixel_x;
         got.y       = rsp_ch.pixel_y;
         got.addr    = rsp_ch.pixel_addr;
         got.color   = rsp_ch.pixel_color;
         got.visible = rsp_ch.visible;
         got.last    = rsp_ch.last;
         board.check_pixel(got);
      end
   end

   function automatic int iabs(int v);
      return v < 0 ? -v : v;
   endfunction

   function automatic int clamp_coord(int v);
      if (v > 32767)
         return 32767;
      if (v < -32768)
         return -32768;
      return v;
   endfunction

   // Mostly around the frame origin, sometimes hugging the coordinate limits
   function automatic int pick_coord();
      case ($urandom_range(0, 9))
         0:       return 32767 - int'($urandom_range(0, 12));
         1:       return -32768 + int'($urandom_range(0, 12));
         default: return int'($urandom_range(0, 112)) - 12;
      endcase
   endfunction

   function automatic line_cmd_type start_cmd(int xs, int ys, int xe, int ye, logic up);
      line_cmd_type cmd;
      cmd.action  = ACTION_START;
      cmd.x_start = COORD_BITS'(xs);
      cmd.y_start = COORD_BITS'(ys);
      cmd.x_end   = COORD_BITS'(xe);
      cmd.y_end   = COORD_BITS'(ye);
      cmd.raised  = up;
      return cmd;
   endfunction

   // Step beats carry junk in the unused fields
   function automatic line_cmd_type step_cmd();
      line_cmd_type cmd;
      cmd         = start_cmd($urandom(), $urandom(), $urandom(), $urandom(), 1'($urandom()));
      cmd.action  = ACTION_STEP;
      return cmd;
   endfunction

   task automatic send_cmd(line_cmd_type cmd);
      int gap;
      gap = req_gap_max > 0 ? $urandom_range(0, req_gap_max) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.action  <= cmd.action;
      req_ch.x_start <= cmd.x_start;
      req_ch.y_start <= cmd.y_start;
      req_ch.x_end   <= cmd.x_end;
      req_ch.y_end   <= cmd.y_end;
      req_ch.raised  <= cmd.raised;
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(cmd);
   endtask

   task automatic send_steps(int count);
      repeat (count) send_cmd(step_cmd());
   endtask

   task automatic send_line(int xs, int ys, int xe, int ye, logic up, int steps);
      send_cmd(start_cmd(xs, ys, xe, ye, up));
      send_steps(steps);
   endtask

   // Drop valid, wait for every due pixel, then let a pending division finish
   task automatic drain_pixels(int settle);
      req_ch.valid <= 1'b0;
      while (board.pixels_due.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      board.write_reg(index, data);
   endtask

   // Frame dimension with junk above the 14 register bits
   function automatic logic [CSR_DATA_W-1:0] dim_word(int v);
      return ($urandom() & ~32'h3FFF) | CSR_DATA_W'(v);
   endfunction

   task automatic program_frame(int phase);
      case (phase)
         1: begin
            write_reg(REG_IMAGE_WIDTH, '1);
            write_reg(REG_IMAGE_HEIGHT, '1);
            write_reg(REG_ROW_STRIDE, '1);
            write_reg(REG_COLOR_RAISED, '1);
            write_reg(REG_COLOR_FLAT, '1);
         end
         2: begin
            write_reg(REG_COLOR_FLAT, '0);
            write_reg(REG_COLOR_RAISED, '0);
            write_reg(REG_ROW_STRIDE, '0);
            write_reg(REG_IMAGE_HEIGHT, '0);
            write_reg(REG_IMAGE_WIDTH, '0);
         end
         5: begin
            write_reg(REG_IMAGE_WIDTH, dim_word(8192));
            write_reg(REG_IMAGE_HEIGHT, dim_word(8192));
            write_reg(REG_ROW_STRIDE, dim_word(8192));
            write_reg(REG_COLOR_RAISED, $urandom());
            write_reg(REG_COLOR_FLAT, $urandom());
         end
         default: begin
            write_reg(REG_IMAGE_WIDTH, dim_word($urandom_range(0, 96)));
            write_reg(REG_IMAGE_HEIGHT, dim_word($urandom_range(0, 96)));
            write_reg(REG_ROW_STRIDE,
                      dim_word($urandom_range(0, 1) ? $urandom_range(0, 128)
                                                    : $urandom_range(0, 16383)));
            write_reg(REG_COLOR_RAISED, $urandom());
            write_reg(REG_COLOR_FLAT, $urandom());
         end
      endcase
      // indexes past the register list must be ignored
      write_reg(FIRST_SPARE_REG + CSR_IDX_W'($urandom_range(0, 2)), $urandom());
      csr_ch.valid <= 1'b0;
   endtask

   // Mostly complete lines, some cut short or overrun, plus junk starts and lone steps
   task automatic random_phase(int beats);
      int sent, kind, reach, span, steps;
      int xs, ys, xe, ye;
      sent = 0;
      while (sent < beats) begin
         kind = $urandom_range(0, 99);
         if (kind < 75) begin
            xs    = pick_coord();
            ys    = pick_coord();
            reach = ($urandom_range(0, 5) == 0) ? 60 : 10;
            xe    = clamp_coord(xs + int'($urandom_range(0, 2 * reach)) - reach);
            ye    = clamp_coord(ys + int'($urandom_range(0, 2 * reach)) - reach);
            span  = iabs(xe - xs) > iabs(ye - ys) ? iabs(xe - xs) : iabs(ye - ys);
            steps = span + 1;
            case ($urandom_range(0, 9))
               0:       steps = $urandom_range(0, span);
               1:       steps += $urandom_range(1, 3);
               default: ;
            endcase
            send_line(xs, ys, xe, ye, 1'($urandom()), steps);
            sent += steps + 1;
         end else if (kind < 85) begin
            steps = $urandom_range(1, 3);
            send_line($urandom(), $urandom(), $urandom(), $urandom(), 1'($urandom()), steps);
            sent += steps + 1;
         end else if (kind < 93) begin
            send_steps(1);
            sent++;
         end else begin
            send_cmd(start_cmd(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                               1'($urandom())));
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      reset          <= 1'b1;
      rsp_hold       <= 1'b0;
      req_ch.valid   <= 1'b0;
      req_ch.action  <= ACTION_STEP;
      req_ch.x_start <= '0;
      req_ch.y_start <= '0;
      req_ch.x_end   <= '0;
      req_ch.y_end   <= '0;
      req_ch.raised  <= 1'b0;
      csr_ch.valid   <= 1'b0;
      csr_ch.index   <= REG_IMAGE_WIDTH;
      csr_ch.data    <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed lines on the reset frame registers
      send_steps(1);                                      // step while idle
      send_line(5, 7, 5, 7, 1'b1, 2);                     // zero length, then idle step
      send_line(-32768, -32768, 32767, 32767, 1'b1, 2);   // widest line, dropped
      send_line(32767, -32768, -32768, 32767, 1'b0, 1);   // opposite diagonal, dropped
      send_line(0, 0, -1, 3, 1'b1, 4);                    // small negative fraction on x
      send_line(1022, 766, 1024, 768, 1'b0, 3);           // crosses the far frame edges
      send_line(10, 10, 13, 12, 1'b0, 4);                 // plain flat line

      for (int phase = 1; phase <= PHASES; phase++) begin
         drain_pixels(SETTLE);
         program_frame(phase);
         req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
         rsp_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
         if (phase == 2) begin
            // pause the request side until every pixel is back
            random_phase(PHASE_BEATS / 2);
            drain_pixels(0);
            random_phase(PHASE_BEATS / 2);
         end else if (phase == 3) begin
            // back-pressure: long sink hold while requests keep coming
            req_gap_max = 0;
            fork
               begin
                  rsp_hold <= 1'b1;
                  repeat (LONG_HOLD) @(posedge clock);
                  rsp_hold <= 1'b0;
               end
               random_phase(PHASE_BEATS);
            join
         end else begin
            random_phase(PHASE_BEATS);
         end
      end

      drain_pixels(SETTLE);
      if (board.errors == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
